FILE: sv/qsee_pkg.sv
// ----------------------------------------------------------------------------
// qsee_pkg
// Shared types and character constants of the quoted string escape encoder.
// ----------------------------------------------------------------------------
package qsee_pkg;

    localparam int MaxChars = 6;

    localparam logic [7:0] ChQuote     = 8'h27;
    localparam logic [7:0] ChDollar    = 8'h24;
    localparam logic [7:0] ChBackslash = 8'h5c;
    localparam logic [7:0] ChEsc       = 8'h1b;
    localparam logic [7:0] ChDel       = 8'h7f;
    localparam logic [7:0] ChSpace     = 8'h20;
    localparam logic [7:0] ChBell      = 8'h07;
    localparam logic [7:0] ChCr        = 8'h0d;
    localparam logic [7:0] ChLowE      = 8'h65;
    localparam logic [7:0] ChLowX      = 8'h78;

    typedef logic [7:0] t_char;
    typedef logic [2:0] t_count;

    // one input item turned into the characters it expands to
    typedef struct packed {
        logic [MaxChars-1:0][7:0] chars;
        t_count                   count;
        logic                     close;
    } t_desc;

endpackage

FILE: sv/qsee_in_if.sv
// ----------------------------------------------------------------------------
// qsee_in_if
// Input channel: one raw byte of the string plus its framing flags.
// ----------------------------------------------------------------------------
interface qsee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       first_of_string;
    logic       last_of_string;

    modport source (
        output valid, data_byte, has_byte, first_of_string, last_of_string,
        input  ready
    );
    modport sink (
        input  valid, data_byte, has_byte, first_of_string, last_of_string,
        output ready
    );
endinterface

FILE: sv/qsee_out_if.sv
// ----------------------------------------------------------------------------
// qsee_out_if
// Output channel: one character of the quoted literal.
// ----------------------------------------------------------------------------
interface qsee_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;
    logic       end_of_literal;

    modport source (
        output valid, out_char, last_of_run, end_of_literal,
        input  ready
    );
    modport sink (
        input  valid, out_char, last_of_run, end_of_literal,
        output ready
    );
endinterface

FILE: sv/quoted_string_escape_encoder.sv
// ----------------------------------------------------------------------------
// quoted_string_escape_encoder
// Escapes a byte string into a single-quoted printable literal.
// ----------------------------------------------------------------------------
// the first character of an item is written into the item queue, then registered in the output stage
// throughput: one output character per cycle while the sink is ready, an item of n characters (1..6)
//   is sent as n characters in a row; the output port is the only serial point
// input is taken back to back until the QueueDepth-entry item queue is full
// reset: synchronous, clears queue pointers and output valid, no clearing pass
module quoted_string_escape_encoder
    import qsee_pkg::*;
#(
    parameter int QueueDepth = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qsee_in_if.sink     i_in,
    qsee_out_if.source  o_out
);

    logic  wr_en;
    t_desc wr_desc;
    logic  q_full;
    logic  q_valid;
    t_desc q_head;
    logic  pop;

    qsee_front u_front (
        .i_in      (i_in),
        .i_full    (q_full),
        .o_wr_en   (wr_en),
        .o_wr_desc (wr_desc)
    );

    qsee_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_desc (wr_desc),
        .i_pop     (pop),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .o_head    (q_head)
    );

    qsee_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

FILE: sv/qsee_front.sv
// ----------------------------------------------------------------------------
// qsee_front
// Accepts input items and classifies each byte into its escaped characters.
// ----------------------------------------------------------------------------
module qsee_front
    import qsee_pkg::*;
(
    qsee_in_if.sink  i_in,
    input  logic     i_full,
    output logic     o_wr_en,
    output t_desc    o_wr_desc
);

    function automatic t_char hex_char(input logic [3:0] d);
        if (d < 4'd10) begin
            return 8'h30 + {4'd0, d};
        end
        return 8'h57 + {4'd0, d};
    endfunction

    function automatic t_char ctrl_letter(input t_char c);
        case (c)
            8'h07:   return 8'h61; // a
            8'h08:   return 8'h62; // b
            8'h09:   return 8'h74; // t
            8'h0a:   return 8'h6e; // n
            8'h0b:   return 8'h76; // v
            8'h0c:   return 8'h66; // f
            8'h0d:   return 8'h72; // r
            default: return ChLowE;
        endcase
    endfunction

    t_desc  desc;
    t_count n;
    t_char  c;

    always_comb begin
        desc = '0;
        n    = '0;
        c    = i_in.data_byte;
        if (i_in.first_of_string) begin
            desc.chars[n] = ChQuote;
            n = n + 3'd1;
        end
        if (i_in.has_byte) begin
            if ((c >= ChBell && c <= ChCr) || c == ChEsc) begin
                desc.chars[n] = ChBackslash;
                n = n + 3'd1;
                desc.chars[n] = ctrl_letter(c);
                n = n + 3'd1;
            end else if (c == ChQuote || c == ChDollar || c == ChBackslash) begin
                desc.chars[n] = ChBackslash;
                n = n + 3'd1;
                desc.chars[n] = c;
                n = n + 3'd1;
            end else if (c < ChSpace || c == ChDel) begin
                desc.chars[n] = ChBackslash;
                n = n + 3'd1;
                desc.chars[n] = ChLowX;
                n = n + 3'd1;
                desc.chars[n] = hex_char(c[7:4]);
                n = n + 3'd1;
                desc.chars[n] = hex_char(c[3:0]);
                n = n + 3'd1;
            end else begin
                desc.chars[n] = c;
                n = n + 3'd1;
            end
        end
        if (i_in.last_of_string) begin
            desc.chars[n] = ChQuote;
            n = n + 3'd1;
        end
        desc.count = n;
        desc.close = i_in.last_of_string;
    end

    assign i_in.ready = !i_full;
    // an item that expands to nothing is consumed without a queue entry
    assign o_wr_en    = i_in.valid && !i_full && (n != 3'd0);
    assign o_wr_desc  = desc;

endmodule

FILE: sv/qsee_queue.sv
// ----------------------------------------------------------------------------
// qsee_queue
// Small register FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module qsee_queue
    import qsee_pkg::*;
#(
    parameter int Depth = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_en,
    input  t_desc i_wr_desc,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_desc o_head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_desc             r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]   r_count;
    logic              do_pop;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_wr_en && !do_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (!i_wr_en && do_pop) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

FILE: sv/qsee_back.sv
// ----------------------------------------------------------------------------
// qsee_back
// Serializes classified items into one output character per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module qsee_back
    import qsee_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_desc    i_q_head,
    output logic     o_pop,
    qsee_out_if.source o_out
);

    t_desc  r_desc;
    t_count r_idx;
    logic   r_busy;
    logic   r_out_valid;
    t_char  r_out_char;
    logic   r_out_last;
    logic   r_out_end;

    logic   adv;
    logic   cur_last;

    assign adv      = !r_out_valid || o_out.ready;
    assign cur_last = (r_idx == r_desc.count - 3'd1);
    assign o_pop    = adv && !r_busy && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else if (adv) begin
            if (r_busy) begin
                r_out_valid <= 1'b1;
                r_busy      <= !cur_last;
                r_idx       <= r_idx + 3'd1;
            end else if (i_q_valid) begin
                r_out_valid <= 1'b1;
                r_busy      <= (i_q_head.count != 3'd1);
                r_idx       <= 3'd1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload side
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_busy) begin
                r_out_char <= r_desc.chars[r_idx];
                r_out_last <= cur_last;
                r_out_end  <= cur_last && r_desc.close;
            end else if (i_q_valid) begin
                r_desc     <= i_q_head;
                r_out_char <= i_q_head.chars[0];
                r_out_last <= (i_q_head.count == 3'd1);
                r_out_end  <= (i_q_head.count == 3'd1) && i_q_head.close;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_char       = r_out_char;
    assign o_out.last_of_run    = r_out_last;
    assign o_out.end_of_literal = r_out_end;

endmodule

FILE: test/qsee_literal_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qsee_literal_checker
// Watches both channels of the escape encoder. Each input transaction is
// expanded into the characters of the quoted literal it should produce. Every
// output transaction is compared field by field against the oldest of them.
// ----------------------------------------------------------------------------
module qsee_literal_checker
    import qsee_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    qsee_in_if    i_in_ch,
    qsee_out_if   i_out_ch,
    output int    o_fail_count,
    output int    o_chars_due
);

    typedef struct packed {
        t_char ch;
        logic  run_end;
        logic  lit_end;
    } t_lit_char;

    // letters for bytes bell through carriage return
    localparam logic [7:0] CtrlLetter [7] = '{"a", "b", "t", "n", "v", "f", "r"};

    t_lit_char literal_chars_due[$];
    int        fail_total;

    function automatic t_char hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? t_char'("0" + nib) : t_char'("a" + nib - 4'd10);
    endfunction

    function automatic void push_char(input t_char ch, input logic lit_end);
        literal_chars_due.push_back('{ch: ch, run_end: 1'b0, lit_end: lit_end});
    endfunction

    // expected characters for one accepted item
    function automatic void escape_item(input t_char b, input logic has,
                                        input logic first, input logic last);
        int before_cnt;
        before_cnt = literal_chars_due.size();
        if (first) begin
            push_char(ChQuote, 1'b0);
        end
        if (has) begin
            if (b >= ChBell && b <= ChCr) begin
                push_char(ChBackslash, 1'b0);
                push_char(CtrlLetter[b - ChBell], 1'b0);
            end else if (b == ChEsc) begin
                push_char(ChBackslash, 1'b0);
                push_char(ChLowE, 1'b0);
            end else if (b == ChQuote || b == ChDollar || b == ChBackslash) begin
                push_char(ChBackslash, 1'b0);
                push_char(b, 1'b0);
            end else if (b < ChSpace || b == ChDel) begin
                push_char(ChBackslash, 1'b0);
                push_char(ChLowX, 1'b0);
                push_char(hex_char(b[7:4]), 1'b0);
                push_char(hex_char(b[3:0]), 1'b0);
            end else begin
                push_char(b, 1'b0);
            end
        end
        if (last) begin
            push_char(ChQuote, 1'b1);
        end
        if (literal_chars_due.size() > before_cnt) begin
            literal_chars_due[literal_chars_due.size() - 1].run_end = 1'b1;
        end
    endfunction

    initial begin
        fail_total   = 0;
        o_fail_count = 0;
        o_chars_due  = 0;
    end

    always @(posedge i_clk) begin : watch
        t_lit_char want;
        if (i_rst_n) begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                escape_item(i_in_ch.data_byte, i_in_ch.has_byte,
                            i_in_ch.first_of_string, i_in_ch.last_of_string);
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (literal_chars_due.size() == 0) begin
                    fail_total = fail_total + 1;
                    $display("%0t: unexpected char: expected none, actual %h",
                             $realtime, i_out_ch.out_char);
                end else begin
                    want = literal_chars_due.pop_front();
                    if (i_out_ch.out_char !== want.ch) begin
                        fail_total = fail_total + 1;
                        $display("%0t: out_char mismatch: expected %h, actual %h",
                                 $realtime, want.ch, i_out_ch.out_char);
                    end
                    if (i_out_ch.last_of_run !== want.run_end) begin
                        fail_total = fail_total + 1;
                        $display("%0t: last_of_run mismatch: expected %b, actual %b",
                                 $realtime, want.run_end, i_out_ch.last_of_run);
                    end
                    if (i_out_ch.end_of_literal !== want.lit_end) begin
                        fail_total = fail_total + 1;
                        $display("%0t: end_of_literal mismatch: expected %b, actual %b",
                                 $realtime, want.lit_end, i_out_ch.end_of_literal);
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_chars_due  <= literal_chars_due.size();
    end

endmodule

FILE: test/tb_quoted_string_escape_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quoted_string_escape_encoder
// Drives byte strings into the escape encoder: a directed set covering every
// escape class, empty strings and odd framing, then random strings and noise
// under three back-pressure regimes. A separate checker judges the output.
// ----------------------------------------------------------------------------
module tb_quoted_string_escape_encoder
    import qsee_pkg::*;
();

    localparam int ItemTarget   = 380;
    localparam int SlowSourceAt = 145;
    localparam int FullRateAt   = 265;
    localparam int LongHoldLen  = 300;
    localparam int StallLimit   = 2000;
    localparam int DrainCycles  = 20;

    typedef enum logic [1:0] {
        PhSlowSink,
        PhSlowSource,
        PhFullRate
    } t_phase;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    t_phase phase;
    int     tx_idle_pct;
    int     items_sent;
    int     fail_count;
    int     chars_due;
    int     quiet_cycles;

    qsee_in_if  in_ch ();
    qsee_out_if out_ch ();

    quoted_string_escape_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    qsee_literal_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_chars_due  (chars_due)
    );

    always #5 i_clk = ~i_clk;

    // bias toward the escape classes
    function automatic t_char pick_byte();
        case ($urandom_range(5))
            0: return t_char'($urandom_range(31));
            1: return t_char'($urandom_range(ChCr, ChBell));
            2: begin
                case ($urandom_range(4))
                    0: return ChQuote;
                    1: return ChDollar;
                    2: return ChBackslash;
                    3: return ChEsc;
                    default: return ChDel;
                endcase
            end
            3: return t_char'($urandom_range(255, 128));
            default: return t_char'($urandom_range(126, 32));
        endcase
    endfunction

    task automatic send_item(input t_char b, input logic has,
                             input logic first, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.data_byte       <= b;
        in_ch.has_byte        <= has;
        in_ch.first_of_string <= first;
        in_ch.last_of_string  <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        if (has || first || last) begin
            items_sent = items_sent + 1;
        end
    endtask

    task automatic send_random_string();
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(5, 1);
        for (int k = 0; k < len; k++) begin
            send_item(pick_byte(), 1'b1, k == 0, k == len - 1);
        end
    endtask

    // stimulus
    initial begin
        int pick;
        i_rst_n               <= 1'b0;
        phase                 <= PhSlowSink;
        in_ch.valid           <= 1'b0;
        in_ch.data_byte       <= 8'h00;
        in_ch.has_byte        <= 1'b0;
        in_ch.first_of_string <= 1'b0;
        in_ch.last_of_string  <= 1'b0;
        tx_idle_pct = 21;
        items_sent  = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty strings, the second with a byte that must be ignored
        send_item(8'h00, 1'b0, 1'b1, 1'b1);
        send_item(8'hff, 1'b0, 1'b1, 1'b1);
        // no byte and no framing: no output at all
        send_item(8'h5a, 1'b0, 1'b0, 1'b0);
        // one string through every escape class
        send_item(8'h00, 1'b1, 1'b1, 1'b0);
        for (int c = ChBell; c <= ChCr; c++) begin
            send_item(t_char'(c), 1'b1, 1'b0, 1'b0);
        end
        send_item(ChEsc, 1'b1, 1'b0, 1'b0);
        send_item(ChQuote, 1'b1, 1'b0, 1'b0);
        send_item(ChDollar, 1'b1, 1'b0, 1'b0);
        send_item(ChBackslash, 1'b1, 1'b0, 1'b0);
        send_item(8'h1f, 1'b1, 1'b0, 1'b0);
        send_item(ChDel, 1'b1, 1'b0, 1'b0);
        send_item(ChSpace, 1'b1, 1'b0, 1'b0);
        send_item(8'h7e, 1'b1, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b0, 1'b1);
        // single-byte string, opening quote mid-string, repeated closing quotes
        send_item(8'h41, 1'b1, 1'b1, 1'b1);
        send_item(8'h0a, 1'b1, 1'b1, 1'b0);
        send_item(8'h33, 1'b0, 1'b1, 1'b0);
        send_item(8'h0e, 1'b1, 1'b0, 1'b1);
        send_item(8'hc3, 1'b0, 1'b0, 1'b1);
        send_item(8'h06, 1'b1, 1'b0, 1'b1);

        while (items_sent < ItemTarget) begin
            if (items_sent >= FullRateAt && tx_idle_pct != 0) begin
                phase       <= PhFullRate;
                tx_idle_pct = 0;
            end else if (items_sent >= SlowSourceAt && items_sent < FullRateAt
                         && tx_idle_pct != 88) begin
                phase       <= PhSlowSource;
                tx_idle_pct = 88;
            end
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_item(t_char'($urandom_range(255)), 1'b0, 1'b1, 1'b1);
            end else if (pick < 16) begin
                send_item(t_char'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                send_random_string();
            end
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (chars_due != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && chars_due == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // output side back-pressure, with one long hold once full rate starts
    initial begin
        int  rx_idle_pct;
        bit  long_hold_done;
        long_hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            case (phase)
                PhSlowSink:   rx_idle_pct = 88;
                PhSlowSource: rx_idle_pct = 21;
                default:      rx_idle_pct = 0;
            endcase
            if (phase == PhFullRate && !long_hold_done) begin
                long_hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LongHoldLen) @(posedge i_clk);
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= StallLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule
